@@ src/mop_pkg.sv @@
package mop_pkg;

   // Default number of palette entries.
   localparam int PALETTE_DEPTH_DEF = 128;

   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 24;
   localparam int PCT_W   = 7;
   localparam int PHASE_W = 7;
   localparam int CSR_INDEX_W = 3;

   // A weighted sum is at most 255 * 100, which fits in 15 bits.
   localparam int SUM_W = 15;

   localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
   localparam logic [COLOR_W-1:0] SYNC_COLOR = 24'h00FFFF;

   // Division by 100 as a multiply by ceil(2^22 / 100) and a shift. The error
   // stays below 0.006 for every sum up to 25500, so the truncated quotient
   // is exact.
   localparam int DIV100_SHIFT = 22;
   localparam int DIV100_RECIP_W = 16;
   localparam logic [DIV100_RECIP_W-1:0] DIV100_RECIP = 16'd41944;
   localparam int DIV100_PROD_W = SUM_W + DIV100_RECIP_W;

   typedef enum logic {
      KIND_PIXEL   = 1'b0,
      KIND_PALETTE = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SHOW_FORE      = 3'd0,
      REG_SHOW_BACK      = 3'd1,
      REG_FILL_COLOR     = 3'd2,
      REG_BACK_COLOR     = 3'd3,
      REG_TRANSPARENCY   = 3'd4,
      REG_SELECTED_PHASE = 3'd5,
      REG_USE_PALETTE    = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                show_fore;
      logic                show_back;
      logic [COLOR_W-1:0]  fill_color;
      logic [COLOR_W-1:0]  back_color;
      logic [PCT_W-1:0]    transparency;
      logic signed [7:0]   selected_phase;
      logic                use_palette;
   } cfg_type;

endpackage

@@ src/mask_overlay_pixel_blend.sv @@
// Pipeline: an accepted pixel request loads the input stage, then the
// weighted-sum stage, then the output register that drives rsp_.
// Throughput: one request per cycle while req_ready is high; the three
// stages move independently, so a stalled output only holds back ready
// once all three stages are full. Reset clears the pipeline and the
// palette valid bits and loads the configuration defaults; every palette
// entry then reads as the yellow sync color.
module mask_overlay_pixel_blend import mop_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [CHAN_W-1:0]      req_mask_value,
   input  logic [CHAN_W-1:0]      req_dest_blue,
   input  logic [CHAN_W-1:0]      req_dest_green,
   input  logic [CHAN_W-1:0]      req_dest_red,
   input  logic [PHASE_W-1:0]     req_palette_index,
   input  logic [COLOR_W-1:0]     req_palette_color,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAN_W-1:0]      rsp_out_blue,
   output logic [CHAN_W-1:0]      rsp_out_green,
   output logic [CHAN_W-1:0]      rsp_out_red,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic req_accept;
   logic pix_accept;
   logic pal_accept;
   logic s1_en;
   logic s2_en;
   logic out_en;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [CHAN_W-1:0] s1_mask_ff;
   logic [CHAN_W-1:0] s1_blue_ff;
   logic [CHAN_W-1:0] s1_green_ff;
   logic [CHAN_W-1:0] s1_red_ff;

   logic [COLOR_W-1:0] pal_color;
   logic [SUM_W-1:0]   sum_blue;
   logic [SUM_W-1:0]   sum_green;
   logic [SUM_W-1:0]   sum_red;

   logic             s2_valid_ff;
   logic             s2_valid_in;
   logic [SUM_W-1:0] s2_blue_ff;
   logic [SUM_W-1:0] s2_green_ff;
   logic [SUM_W-1:0] s2_red_ff;

   logic [CHAN_W-1:0] quot_blue;
   logic [CHAN_W-1:0] quot_green;
   logic [CHAN_W-1:0] quot_red;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [CHAN_W-1:0] out_blue_ff;
   logic [CHAN_W-1:0] out_green_ff;
   logic [CHAN_W-1:0] out_red_ff;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SHOW_FORE:      cfg_in.show_fore      = csr_data[0];
            REG_SHOW_BACK:      cfg_in.show_back      = csr_data[0];
            REG_FILL_COLOR:     cfg_in.fill_color     = csr_data;
            REG_BACK_COLOR:     cfg_in.back_color     = csr_data;
            REG_TRANSPARENCY:   cfg_in.transparency   = csr_data[PCT_W-1:0];
            REG_SELECTED_PHASE: cfg_in.selected_phase = signed'(csr_data[7:0]);
            REG_USE_PALETTE:    cfg_in.use_palette    = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.show_fore      <= 1'b1;
         cfg_ff.show_back      <= 1'b0;
         cfg_ff.fill_color     <= '0;
         cfg_ff.back_color     <= '0;
         cfg_ff.transparency   <= '0;
         cfg_ff.selected_phase <= -8'sd1;
         cfg_ff.use_palette    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Each stage loads whenever the stage after it can take its contents.
   assign out_en = !out_valid_ff || rsp_ready;
   assign s2_en  = !s2_valid_ff || out_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_ready  = s1_en;
   assign req_accept = req_valid && req_ready;
   assign pix_accept = req_accept && (req_kind == KIND_PIXEL);
   assign pal_accept = req_accept && (req_kind == KIND_PALETTE);

   // Input stage; the palette read runs alongside it.
   assign s1_valid_in = s1_en ? pix_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_mask_ff  <= req_mask_value;
         s1_blue_ff  <= req_dest_blue;
         s1_green_ff <= req_dest_green;
         s1_red_ff   <= req_dest_red;
      end
   end

   mop_palette #(
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_accept),
      .wr_index (req_palette_index),
      .wr_color (req_palette_color),
      .rd_en    (pix_accept),
      .rd_phase (req_mask_value[PHASE_W-1:0]),
      .rd_color (pal_color)
   );

   mop_blend u_blend (
      .cfg        (cfg_ff),
      .mask_value (s1_mask_ff),
      .dest_blue  (s1_blue_ff),
      .dest_green (s1_green_ff),
      .dest_red   (s1_red_ff),
      .pal_color  (pal_color),
      .sum_blue   (sum_blue),
      .sum_green  (sum_green),
      .sum_red    (sum_red)
   );

   // Weighted-sum stage
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_blue_ff  <= sum_blue;
         s2_green_ff <= sum_green;
         s2_red_ff   <= sum_red;
      end
   end

   mop_div100 u_div_blue  (.sum (s2_blue_ff),  .quot (quot_blue));
   mop_div100 u_div_green (.sum (s2_green_ff), .quot (quot_green));
   mop_div100 u_div_red   (.sum (s2_red_ff),   .quot (quot_red));

   // Output register
   assign out_valid_in = out_en ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s2_valid_ff) begin
         out_blue_ff  <= quot_blue;
         out_green_ff <= quot_green;
         out_red_ff   <= quot_red;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_red   = out_red_ff;

`ifndef NO_ASSERTIONS
   // A palette write never produces a result.
   a_pal_no_result: assert property (@(posedge clock) disable iff (reset)
      pal_accept |=> !s1_valid_ff)
      else $error("palette write entered the pixel pipeline");

   // Every accepted pixel enters the input stage.
   a_pix_enters: assert property (@(posedge clock) disable iff (reset)
      pix_accept |=> s1_valid_ff)
      else $error("accepted pixel request was lost");

   // Requests are refused only when every stage holds a pixel.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && out_valid_ff))
      else $error("request refused while the pipeline has a free stage");

   // A new result only comes from the weighted-sum stage.
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without a pixel behind it");
`endif

endmodule

@@ src/mop_ram.sv @@
module mop_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mop_palette.sv @@
module mop_palette import mop_pkg::*; #(
   parameter int DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [PHASE_W-1:0] wr_index,
   input  logic [COLOR_W-1:0] wr_color,
   input  logic               rd_en,
   input  logic [PHASE_W-1:0] rd_phase,
   output logic [COLOR_W-1:0] rd_color
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic               wr_ok;
   logic               rd_ok;
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic               hit_ff;
   logic [COLOR_W-1:0] ram_q;

   assign wr_addr = AW'(wr_index);
   assign rd_addr = AW'(rd_phase);
   assign wr_ok   = wr_en && ({2'b00, wr_index} < 9'(DEPTH));
   assign rd_ok   = {2'b00, rd_phase} < 9'(DEPTH);

   // An entry never written since reset reads as the sync color.
   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         hit_ff <= rd_ok && valid_ff[rd_addr];
      end
   end

   mop_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_color),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_color = hit_ff ? ram_q : SYNC_COLOR;

endmodule

@@ src/mop_blend.sv @@
module mop_blend import mop_pkg::*; (
   input  cfg_type             cfg,
   input  logic [CHAN_W-1:0]   mask_value,
   input  logic [CHAN_W-1:0]   dest_blue,
   input  logic [CHAN_W-1:0]   dest_green,
   input  logic [CHAN_W-1:0]   dest_red,
   input  logic [COLOR_W-1:0]  pal_color,
   output logic [SUM_W-1:0]    sum_blue,
   output logic [SUM_W-1:0]    sum_green,
   output logic [SUM_W-1:0]    sum_red
);

   logic               back;
   logic               shown;
   logic [COLOR_W-1:0] color;
   logic [PCT_W-1:0]   t_clamp;
   logic [PCT_W-1:0]   t_eff;
   logic [PCT_W-1:0]   w_color;

   always_comb begin
      t_clamp = (cfg.transparency > PCT_FULL) ? PCT_FULL : cfg.transparency;

      // In palette mode an unselected phase drops to background.
      back = !mask_value[7] ||
             (cfg.use_palette && !cfg.selected_phase[7] &&
              (cfg.selected_phase[PHASE_W-1:0] != mask_value[PHASE_W-1:0]));

      if (back) begin
         shown = cfg.show_back;
         color = cfg.back_color;
      end else begin
         shown = cfg.show_fore;
         color = cfg.use_palette ? pal_color : cfg.fill_color;
      end

      // Full transparency passes the destination through exactly.
      t_eff   = shown ? t_clamp : PCT_FULL;
      w_color = PCT_FULL - t_eff;
   end

   assign sum_blue  = SUM_W'(color[23:16]) * SUM_W'(w_color) +
                      SUM_W'(dest_blue) * SUM_W'(t_eff);
   assign sum_green = SUM_W'(color[15:8]) * SUM_W'(w_color) +
                      SUM_W'(dest_green) * SUM_W'(t_eff);
   assign sum_red   = SUM_W'(color[7:0]) * SUM_W'(w_color) +
                      SUM_W'(dest_red) * SUM_W'(t_eff);

endmodule

@@ src/mop_div100.sv @@
module mop_div100 import mop_pkg::*; (
   input  logic [SUM_W-1:0]  sum,
   output logic [CHAN_W-1:0] quot
);

   logic [DIV100_PROD_W-1:0] prod;

   assign prod = DIV100_PROD_W'(sum) * DIV100_PROD_W'(DIV100_RECIP);
   assign quot = prod[DIV100_SHIFT +: CHAN_W];

endmodule

@@ verif/mop_checker.sv @@
`timescale 1ns / 1ps

module mop_checker import mop_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_kind,
   input  logic [CHAN_W-1:0]      req_mask_value,
   input  logic [CHAN_W-1:0]      req_dest_blue,
   input  logic [CHAN_W-1:0]      req_dest_green,
   input  logic [CHAN_W-1:0]      req_dest_red,
   input  logic [PHASE_W-1:0]     req_palette_index,
   input  logic [COLOR_W-1:0]     req_palette_color,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [CHAN_W-1:0]      rsp_out_blue,
   input  logic [CHAN_W-1:0]      rsp_out_green,
   input  logic [CHAN_W-1:0]      rsp_out_red,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data,

   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   cfg_type            cfg;
   logic [COLOR_W-1:0] palette [PALETTE_DEPTH_DEF];
   pixel_type          blended_pixels [$];
   int                 mismatches = 0;

   function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] colour,
                                                      input logic [CHAN_W-1:0] dest,
                                                      input logic [PCT_W-1:0] t);
      int c;
      int d;
      int keep;
      c = int'(colour);
      d = int'(dest);
      keep = int'(t);
      return CHAN_W'((c * (100 - keep) + d * keep) / 100);
   endfunction

   function automatic pixel_type blend_pixel(input logic [CHAN_W-1:0] mask,
                                             input logic [CHAN_W-1:0] blue,
                                             input logic [CHAN_W-1:0] green,
                                             input logic [CHAN_W-1:0] red);
      logic [PCT_W-1:0]   t;
      logic               is_back;
      logic               shown;
      logic [COLOR_W-1:0] colour;
      pixel_type          pix;
      t = (cfg.transparency > PCT_FULL) ? PCT_FULL : cfg.transparency;
      // With the palette in use and one phase selected, every other phase is background.
      is_back = !mask[7] || (cfg.use_palette && !cfg.selected_phase[7] &&
                             cfg.selected_phase[6:0] != mask[6:0]);
      if (is_back) begin
         shown = cfg.show_back;
         colour = cfg.back_color;
      end else begin
         shown = cfg.show_fore;
         colour = cfg.use_palette ? palette[mask[6:0]] : cfg.fill_color;
      end
      if (shown) begin
         pix.blue  = mix_channel(colour[23:16], blue, t);
         pix.green = mix_channel(colour[15:8], green, t);
         pix.red   = mix_channel(colour[7:0], red, t);
      end else begin
         pix = '{blue: blue, green: green, red: red};
      end
      return pix;
   endfunction

   task automatic compare_channel(input string name, input logic [CHAN_W-1:0] expected,
                                  input logic [CHAN_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type exp_pix;
      if (reset) begin
         cfg = '{show_fore: 1'b1, show_back: 1'b0, fill_color: '0, back_color: '0,
                 transparency: '0, selected_phase: -8'sd1, use_palette: 1'b0};
         for (int i = 0; i < PALETTE_DEPTH_DEF; i++) begin
            palette[i] = SYNC_COLOR;
         end
         blended_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (blended_pixels.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
                        rsp_out_blue, rsp_out_green, rsp_out_red);
               mismatches++;
            end else begin
               exp_pix = blended_pixels.pop_front();
               compare_channel("blue", exp_pix.blue, rsp_out_blue);
               compare_channel("green", exp_pix.green, rsp_out_green);
               compare_channel("red", exp_pix.red, rsp_out_red);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SHOW_FORE:      cfg.show_fore = csr_data[0];
               REG_SHOW_BACK:      cfg.show_back = csr_data[0];
               REG_FILL_COLOR:     cfg.fill_color = csr_data;
               REG_BACK_COLOR:     cfg.back_color = csr_data;
               REG_TRANSPARENCY:   cfg.transparency = csr_data[PCT_W-1:0];
               REG_SELECTED_PHASE: cfg.selected_phase = csr_data[7:0];
               REG_USE_PALETTE:    cfg.use_palette = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_PALETTE) begin
               palette[req_palette_index] = req_palette_color;
            end else begin
               blended_pixels.push_back(blend_pixel(req_mask_value, req_dest_blue,
                                                    req_dest_green, req_dest_red));
            end
         end
      end
      fail_count <= mismatches;
      pending <= blended_pixels.size();
   end

endmodule

@@ verif/tb_mask_overlay_pixel_blend.sv @@
`timescale 1ns / 1ps

module tb_mask_overlay_pixel_blend;
   import mop_pkg::*;

   localparam int          NUM_PHASES      = 12;
   localparam int          ITEMS_PER_PHASE = 75;
   localparam int          DRAIN_PAD       = 8;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_kind = KIND_PIXEL;
   logic [CHAN_W-1:0]      req_mask_value = '0;
   logic [CHAN_W-1:0]      req_dest_blue = '0;
   logic [CHAN_W-1:0]      req_dest_green = '0;
   logic [CHAN_W-1:0]      req_dest_red = '0;
   logic [PHASE_W-1:0]     req_palette_index = '0;
   logic [COLOR_W-1:0]     req_palette_color = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAN_W-1:0]      rsp_out_blue;
   logic [CHAN_W-1:0]      rsp_out_green;
   logic [CHAN_W-1:0]      rsp_out_red;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]     csr_data = '0;

   int                     fail_count;
   int                     pending;
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int unsigned            cycle_count = 0;
   logic [7:0]             cur_sel = 8'hFF;
   logic                   cur_pal = 1'b0;

   mask_overlay_pixel_blend u_top (.*);

   mop_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Valid stays high after acceptance; only an idle next request or drain_results lowers it.
   task automatic send_req(input kind_type kind, input logic [7:0] mask,
                           input logic [7:0] blue, input logic [7:0] green,
                           input logic [7:0] red, input logic [6:0] pidx,
                           input logic [23:0] pcol);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_mask_value <= mask;
      req_dest_blue <= blue;
      req_dest_green <= green;
      req_dest_red <= red;
      req_palette_index <= pidx;
      req_palette_color <= pcol;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [23:0] sf, input logic [23:0] sb,
                               input logic [23:0] fill, input logic [23:0] back,
                               input logic [23:0] t, input logic [23:0] sel,
                               input logic [23:0] pal);
      write_reg(REG_SHOW_FORE, sf);
      write_reg(REG_SHOW_BACK, sb);
      write_reg(REG_FILL_COLOR, fill);
      write_reg(REG_BACK_COLOR, back);
      write_reg(REG_TRANSPARENCY, t);
      write_reg(REG_SELECTED_PHASE, sel);
      write_reg(REG_USE_PALETTE, pal);
      cur_sel = sel[7:0];
      cur_pal = pal[0];
   endtask

   initial begin
      logic [23:0] t_data;
      logic [23:0] sel_data;
      logic [7:0]  mask;
      logic [6:0]  pidx;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: foreground goes to black fill, background passes through.
      send_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 24'hFFFFFF);
      send_req(KIND_PIXEL, 8'h80, 8'h00, 8'h00, 8'h00, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 7'h00, 24'h000000);
      drain_results();

      // Full transparency keeps the destination on both classes.
      write_config(24'h1, 24'h1, 24'hFFFFFF, 24'h123456, 24'd100, 24'hFF, 24'h0);
      write_reg(REG_UNUSED, 24'hFFFFFF);
      send_req(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 8'hFF, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h00, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h80, 8'h12, 8'h34, 8'h56, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h7F, 8'hAB, 8'hCD, 8'hEF, 7'h00, 24'h000000);
      drain_results();

      // Transparency above 100 is clamped.
      write_reg(REG_TRANSPARENCY, 24'd127);
      send_req(KIND_PIXEL, 8'hC0, 8'h11, 8'h22, 8'h33, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h10, 8'hFE, 8'h01, 8'h80, 7'h00, 24'h000000);
      drain_results();

      // Palette entries at both ends, one in the middle; phase 1 stays at the sync color.
      write_reg(REG_TRANSPARENCY, 24'd0);
      send_req(KIND_PALETTE, 8'h00, 8'h00, 8'h00, 8'h00, 7'h00, 24'hFFFFFF);
      send_req(KIND_PALETTE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F, 24'h000000);
      send_req(KIND_PALETTE, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 7'h05, 24'hA5C3E1);
      drain_results();
      write_config(24'h1, 24'h1, 24'h000000, 24'hFFFFFF, 24'd0, 24'hFF, 24'h1);
      send_req(KIND_PIXEL, 8'h80, 8'h00, 8'h00, 8'h00, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h85, 8'h40, 8'h80, 8'hC0, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h81, 8'h40, 8'h80, 8'hC0, 7'h00, 24'h000000);
      drain_results();

      // A selected phase turns the other phases into background.
      write_config(24'h1, 24'h1, 24'h000000, 24'h00FF00, 24'd50, 24'h05, 24'h1);
      send_req(KIND_PIXEL, 8'h85, 8'h10, 8'h20, 8'h30, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h86, 8'h10, 8'h20, 8'h30, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h05, 8'h10, 8'h20, 8'h30, 7'h00, 24'h000000);
      drain_results();
      write_reg(REG_SELECTED_PHASE, 24'h80);
      send_req(KIND_PIXEL, 8'h86, 8'h10, 8'h20, 8'h30, 7'h00, 24'h000000);
      drain_results();

      // Neither class shown: everything passes through.
      write_config(24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'd37, 24'hFF, 24'h0);
      send_req(KIND_PIXEL, 8'hFF, 8'h01, 8'h02, 8'h03, 7'h00, 24'h000000);
      send_req(KIND_PIXEL, 8'h00, 8'hFD, 8'hFE, 8'hFF, 7'h00, 24'h000000);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain_results();
         if (ph < 4) begin
            send_idle_pct = 32;
            recv_idle_pct = 86;
         end else if (ph < 8) begin
            send_idle_pct = 86;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         t_data = 24'($urandom);
         case ($urandom_range(4))
            0: t_data[6:0] = 7'd0;
            1: t_data[6:0] = 7'd100;
            2: t_data[6:0] = 7'($urandom_range(127, 101));
            default: t_data[6:0] = 7'($urandom_range(100));
         endcase
         sel_data = 24'($urandom);
         case ($urandom_range(4))
            0: sel_data[7:0] = 8'hFF;
            1: sel_data[7:0] = 8'($urandom_range(255, 128));
            2: sel_data[7:0] = $urandom_range(1) ? 8'd127 : 8'd0;
            default: sel_data[7:0] = 8'($urandom_range(127));
         endcase
         write_config(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      t_data, sel_data, 24'($urandom));

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               drain_results();
            end
            // About half the pixels hit the selected phase, so palette colors get blended.
            mask = 8'($urandom);
            if (cur_pal && !cur_sel[7] && $urandom_range(99) < 50) begin
               mask = {1'b1, cur_sel[6:0]};
            end
            pidx = 7'($urandom);
            if ($urandom_range(99) < 30) begin
               pidx = cur_sel[6:0];
            end
            if ($urandom_range(99) < 15) begin
               send_req(KIND_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), pidx, 24'($urandom));
            end else begin
               send_req(KIND_PIXEL, mask, 8'($urandom), 8'($urandom), 8'($urandom),
                        7'($urandom), 24'($urandom));
            end
         end
      end

      drain_results();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
